// ===== design/vggs_pkg.sv =====
// package for the vad gated gain smoother: widths, reset values, register indexes
// and the microcode table of the sequencer; no dependencies
package vggs_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int HANG_BITS_DEF   = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 16;
    localparam int PROB_W     = 16;
    localparam int GATE_W     = 15;
    localparam int GRACE_W    = 8;
    localparam int ALPHA_W    = 16;
    localparam int FRAC_BITS  = 15;

    localparam logic [ALPHA_W:0] ALPHA_ONE = 17'h10000;

    localparam logic                RST_MONO_MODE = 1'b1;
    localparam logic [GATE_W-1:0]   RST_GATE_THR  = 15'd33;
    localparam logic [ALPHA_W-1:0]  RST_ALPHA     = 16'd64225;
    localparam logic [GAIN_W-1:0]   RST_MIN_GAIN  = 16'd3277;
    localparam logic [GAIN_W-1:0]   RST_MAX_GAIN  = 16'd32768;
    localparam logic [PROB_W-1:0]   RST_VOICE_THR = 16'd32768;
    localparam logic [GRACE_W-1:0]  RST_GRACE     = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MONO_MODE    = 3'd0,
        REG_GATE_THR     = 3'd1,
        REG_ALPHA        = 3'd2,
        REG_MIN_GAIN     = 3'd3,
        REG_MAX_GAIN     = 3'd4,
        REG_VOICE_THR    = 3'd5,
        REG_GRACE_BLOCKS = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_IDLE    = 4'd1,
        OP_FRAME   = 4'd2,
        OP_MUL_OLD = 4'd3,
        OP_MUL_TGT = 4'd4,
        OP_ACC     = 4'd5,
        OP_GAIN    = 4'd6,
        OP_MUL_OUT = 4'd7,
        OP_OUT     = 4'd8,
        OP_EMIT    = 4'd9
    } t_op;

    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_GOTO     = 3'd1,
        J_WAIT_IN  = 3'd2,
        J_MONO     = 3'd3,
        J_WAIT_OUT = 3'd4
    } t_jmp;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_IDLE = 4'd0;
    localparam t_step ST_EMIT = 4'd14;

    localparam logic CH_L = 1'b0;
    localparam logic CH_R = 1'b1;

    typedef struct packed {
        t_op   op;
        logic  ch;
        t_jmp  jmp;
        t_step target;
    } t_ctrl;

    // control store: left channel, then right channel unless mono
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '{op: OP_NOP, ch: CH_L, jmp: J_GOTO, target: ST_IDLE};
        case (step)
            4'd0:  w = '{op: OP_IDLE,    ch: CH_L, jmp: J_WAIT_IN,  target: ST_IDLE};
            4'd1:  w = '{op: OP_FRAME,   ch: CH_L, jmp: J_NEXT,     target: ST_IDLE};
            4'd2:  w = '{op: OP_MUL_OLD, ch: CH_L, jmp: J_NEXT,     target: ST_IDLE};
            4'd3:  w = '{op: OP_MUL_TGT, ch: CH_L, jmp: J_NEXT,     target: ST_IDLE};
            4'd4:  w = '{op: OP_ACC,     ch: CH_L, jmp: J_NEXT,     target: ST_IDLE};
            4'd5:  w = '{op: OP_GAIN,    ch: CH_L, jmp: J_NEXT,     target: ST_IDLE};
            4'd6:  w = '{op: OP_MUL_OUT, ch: CH_L, jmp: J_NEXT,     target: ST_IDLE};
            4'd7:  w = '{op: OP_OUT,     ch: CH_L, jmp: J_MONO,     target: ST_EMIT};
            4'd8:  w = '{op: OP_MUL_OLD, ch: CH_R, jmp: J_NEXT,     target: ST_IDLE};
            4'd9:  w = '{op: OP_MUL_TGT, ch: CH_R, jmp: J_NEXT,     target: ST_IDLE};
            4'd10: w = '{op: OP_ACC,     ch: CH_R, jmp: J_NEXT,     target: ST_IDLE};
            4'd11: w = '{op: OP_GAIN,    ch: CH_R, jmp: J_NEXT,     target: ST_IDLE};
            4'd12: w = '{op: OP_MUL_OUT, ch: CH_R, jmp: J_NEXT,     target: ST_IDLE};
            4'd13: w = '{op: OP_OUT,     ch: CH_R, jmp: J_NEXT,     target: ST_IDLE};
            4'd14: w = '{op: OP_EMIT,    ch: CH_L, jmp: J_WAIT_OUT, target: ST_IDLE};
            default: w = '{op: OP_NOP, ch: CH_L, jmp: J_GOTO, target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/vggs_in_if.sv =====
// input channel of the vad gated gain smoother: valid/ready plus one sample pair item
// depends on vggs_pkg for the default sample width and the probability width
interface vggs_in_if #(
    parameter int SAMPLE_BITS = vggs_pkg::SAMPLE_BITS_DEF
);
    logic                                   valid;
    logic                                   ready;
    logic signed [SAMPLE_BITS-1:0]          left_sample;
    logic signed [SAMPLE_BITS-1:0]          right_sample;
    logic                                   frame_start;
    logic [vggs_pkg::PROB_W-1:0]            voice_prob_left;
    logic [vggs_pkg::PROB_W-1:0]            voice_prob_right;

    modport source (
        output valid, left_sample, right_sample, frame_start,
               voice_prob_left, voice_prob_right,
        input  ready
    );
    modport sink (
        input  valid, left_sample, right_sample, frame_start,
               voice_prob_left, voice_prob_right,
        output ready
    );
endinterface

// ===== design/vggs_out_if.sv =====
// output channel of the vad gated gain smoother: valid/ready plus one gated sample pair
// depends on vggs_pkg for the default sample width
interface vggs_out_if #(
    parameter int SAMPLE_BITS = vggs_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (
        output valid, left_out, right_out,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out,
        output ready
    );
endinterface

// ===== design/vad_gated_gain_smoother_top.sv =====
// top level of the vad gated gain smoother: microcoded sequencer and shared datapath
// depends on vggs_pkg, vggs_in_if and vggs_out_if
//
// Noise gate for Q15 sample pairs with voice-activity hangover and a one-pole smoothed
// gain. One item is taken at a time: the control program runs a mono item through the
// left channel steps only and a stereo item through both channels to the output register,
// and the input is ready again in the cycle after it is loaded there. The program runs every
// product (old gain times alpha, target times one minus alpha, sample times gain) through
// a single multiplier with a register after it. A finished item waits in the output
// register while the next one is taken. Configuration must be written through the plain
// write port only while the block is idle; the block itself does not enforce this.
module vad_gated_gain_smoother_top #(
    parameter int SAMPLE_BITS = vggs_pkg::SAMPLE_BITS_DEF,
    parameter int HANG_BITS   = vggs_pkg::HANG_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [vggs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vggs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    vggs_in_if.sink                           i_in,
    vggs_out_if.source                        o_out
);
    import vggs_pkg::*;

    localparam int MA_W  = ((SAMPLE_BITS > GAIN_W + 2) ? SAMPLE_BITS : GAIN_W + 2) + 1;
    localparam int MB_W  = GAIN_W + 1;
    localparam int P_W   = MA_W + MB_W;
    localparam int ACC_W = 2 * GAIN_W;
    localparam int CMP_W = SAMPLE_BITS + FRAC_BITS;
    localparam int HC_W  = (HANG_BITS > GRACE_W) ? HANG_BITS : GRACE_W;

    localparam logic signed [P_W-1:0] SMAX = P_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [P_W-1:0] SMIN = P_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [P_W-1:0] RND_OUT  = P_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic [ACC_W-1:0]      RND_GAIN = ACC_W'(64'd1 << (GAIN_W - 1));

    // configuration
    logic                  r_mono_mode;
    logic [GATE_W-1:0]     r_gate_thr;
    logic [ALPHA_W-1:0]    r_alpha;
    logic [GAIN_W-1:0]     r_min_gain;
    logic [GAIN_W-1:0]     r_max_gain;
    logic [PROB_W-1:0]     r_voice_thr;
    logic [GRACE_W-1:0]    r_grace;

    // state
    logic [GAIN_W-1:0]     r_gain_mono;
    logic [GAIN_W-1:0]     r_gain_l;
    logic [GAIN_W-1:0]     r_gain_r;
    logic [HANG_BITS-1:0]  r_hang_mono;
    logic [HANG_BITS-1:0]  r_hang_st;
    logic                  r_unmuted;
    t_step                 r_step;
    t_step                 n_step;
    logic                  r_out_valid;
    logic                  n_out_valid;

    // payload
    logic signed [SAMPLE_BITS-1:0] r_xl;
    logic signed [SAMPLE_BITS-1:0] r_xr;
    logic                          r_fs;
    logic [PROB_W-1:0]             r_pl;
    logic [PROB_W-1:0]             r_pr;
    logic signed [P_W-1:0]         r_prod;
    logic [ACC_W-1:0]              r_acc;
    logic signed [SAMPLE_BITS-1:0] r_yl;
    logic signed [SAMPLE_BITS-1:0] r_yr;
    logic signed [SAMPLE_BITS-1:0] r_out_l;
    logic signed [SAMPLE_BITS-1:0] r_out_r;

    t_ctrl                         w;
    logic                          in_fire;
    logic                          out_free;
    logic signed [SAMPLE_BITS-1:0] x_cur;
    logic [SAMPLE_BITS-1:0]        mag;
    logic                          loud;
    logic [GAIN_W-1:0]             g_cur;
    logic [GAIN_W-1:0]             target;
    logic [ALPHA_W:0]              alpha_c;
    logic signed [MA_W-1:0]        ma;
    logic signed [MB_W-1:0]        mb;
    logic signed [P_W-1:0]         prod;
    logic [ACC_W-1:0]              sum_r;
    logic [GAIN_W-1:0]             ng_raw;
    logic [GAIN_W-1:0]             ng_hi;
    logic [GAIN_W-1:0]             ng;
    logic signed [P_W-1:0]         y_rnd;
    logic signed [P_W-1:0]         y_shift;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic [PROB_W-1:0]             prob;
    logic                          voice;
    logic [HANG_BITS-1:0]          hang_cur;
    logic [HANG_BITS-1:0]          hang_nx;
    logic                          unmuted_nx;

    assign w        = ucode(r_step);
    assign i_in.ready = (w.op == OP_IDLE);
    assign in_fire  = i_in.valid & i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;

    // gate and target gain
    always_comb begin
        x_cur  = (w.ch == CH_R) ? r_xr : r_xl;
        mag    = x_cur[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_cur) : x_cur;
        loud   = {mag, {FRAC_BITS{1'b0}}} >
                 CMP_W'({r_gate_thr, {(SAMPLE_BITS - 1){1'b0}}});
        g_cur  = r_mono_mode ? r_gain_mono : ((w.ch == CH_R) ? r_gain_r : r_gain_l);
        target = (r_unmuted && loud) ? r_max_gain : r_min_gain;
        alpha_c = ALPHA_ONE - {1'b0, r_alpha};
    end

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (w.op)
            OP_MUL_OLD: begin
                ma = MA_W'({1'b0, r_alpha});
                mb = {1'b0, g_cur};
            end
            OP_MUL_TGT: begin
                ma = MA_W'({1'b0, alpha_c});
                mb = {1'b0, target};
            end
            OP_MUL_OUT: begin
                ma = MA_W'(x_cur);
                mb = {1'b0, g_cur};
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod = P_W'(ma) * P_W'(mb);
    end

    // gain rounding and clamp, output rounding and saturation
    always_comb begin
        sum_r   = r_acc + RND_GAIN;
        ng_raw  = sum_r[ACC_W-1:GAIN_W];
        ng_hi   = (ng_raw > r_max_gain) ? r_max_gain : ng_raw;
        ng      = (ng_hi < r_min_gain) ? r_min_gain : ng_hi;
        y_rnd   = r_prod + RND_OUT;
        y_shift = y_rnd >>> FRAC_BITS;
        if (y_shift > SMAX) begin
            y_sat = SMAX[SAMPLE_BITS-1:0];
        end else if (y_shift < SMIN) begin
            y_sat = SMIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = y_shift[SAMPLE_BITS-1:0];
        end
    end

    // frame decision and hang counter
    always_comb begin
        prob     = (r_mono_mode || (r_pl >= r_pr)) ? r_pl : r_pr;
        voice    = (prob >= r_voice_thr);
        hang_cur = r_mono_mode ? r_hang_mono : r_hang_st;
        if (voice) begin
            hang_nx = '0;
        end else if (&hang_cur) begin
            hang_nx = hang_cur;
        end else begin
            hang_nx = hang_cur + 1'b1;
        end
        unmuted_nx = voice || (HC_W'(hang_nx) < HC_W'(r_grace));
    end

    // sequencer
    always_comb begin
        case (w.jmp)
            J_NEXT:     n_step = r_step + 1'b1;
            J_GOTO:     n_step = w.target;
            J_WAIT_IN:  n_step = in_fire ? (r_step + 1'b1) : r_step;
            J_MONO:     n_step = r_mono_mode ? w.target : (r_step + 1'b1);
            J_WAIT_OUT: n_step = out_free ? w.target : r_step;
            default:    n_step = ST_IDLE;
        endcase
        if ((w.op == OP_EMIT) && out_free) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_mode <= RST_MONO_MODE;
            r_gate_thr  <= RST_GATE_THR;
            r_alpha     <= RST_ALPHA;
            r_min_gain  <= RST_MIN_GAIN;
            r_max_gain  <= RST_MAX_GAIN;
            r_voice_thr <= RST_VOICE_THR;
            r_grace     <= RST_GRACE;
            r_gain_mono <= RST_MIN_GAIN;
            r_gain_l    <= RST_MIN_GAIN;
            r_gain_r    <= RST_MIN_GAIN;
            r_hang_mono <= '0;
            r_hang_st   <= '0;
            r_unmuted   <= 1'b0;
            r_step      <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_MONO_MODE:    r_mono_mode <= i_cfg_data[0];
                    REG_GATE_THR:     r_gate_thr  <= i_cfg_data[GATE_W-1:0];
                    REG_ALPHA:        r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                    REG_MIN_GAIN:     r_min_gain  <= i_cfg_data[GAIN_W-1:0];
                    REG_MAX_GAIN:     r_max_gain  <= i_cfg_data[GAIN_W-1:0];
                    REG_VOICE_THR:    r_voice_thr <= i_cfg_data[PROB_W-1:0];
                    REG_GRACE_BLOCKS: r_grace     <= i_cfg_data[GRACE_W-1:0];
                    default: ;
                endcase
            end
            if ((w.op == OP_FRAME) && r_fs) begin
                r_unmuted <= unmuted_nx;
                if (r_mono_mode) begin
                    r_hang_mono <= hang_nx;
                end else begin
                    r_hang_st <= hang_nx;
                end
            end
            if (w.op == OP_GAIN) begin
                if (r_mono_mode) begin
                    r_gain_mono <= ng;
                end else if (w.ch == CH_R) begin
                    r_gain_r <= ng;
                end else begin
                    r_gain_l <= ng;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_xl <= i_in.left_sample;
            r_xr <= i_in.right_sample;
            r_fs <= i_in.frame_start;
            r_pl <= i_in.voice_prob_left;
            r_pr <= i_in.voice_prob_right;
        end
        case (w.op)
            OP_MUL_OLD, OP_MUL_OUT: begin
                r_prod <= prod;
            end
            OP_MUL_TGT: begin
                r_acc  <= r_prod[ACC_W-1:0];
                r_prod <= prod;
            end
            OP_ACC: begin
                r_acc <= r_acc + r_prod[ACC_W-1:0];
            end
            OP_OUT: begin
                if (w.ch == CH_R) begin
                    r_yr <= y_sat;
                end else begin
                    r_yl <= y_sat;
                    if (r_mono_mode) begin
                        r_yr <= y_sat;
                    end
                end
            end
            default: ;
        endcase
        if ((w.op == OP_EMIT) && out_free) begin
            r_out_l <= r_yl;
            r_out_r <= r_yr;
        end
    end

endmodule

// ===== sim/vad_gated_gain_smoother_top_test.sv =====
`timescale 1ns / 100ps

// testbench for vad_gated_gain_smoother_top: random and directed sample pair items with frame
// markers, every gated pair checked against a model of the gate, hangover and gain smoother
// depends on vggs_pkg, vggs_in_if, vggs_out_if and vad_gated_gain_smoother_top

module vad_gated_gain_smoother_top_test;
    import vggs_pkg::*;

    localparam int SW            = SAMPLE_BITS_DEF;
    localparam int HB            = HANG_BITS_DEF;
    localparam int CLK_PERIOD    = 20;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int ITEM_TARGET   = 1550;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 700;
    localparam int HANG_ITEMS    = 280;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 frame_start;
        logic [PROB_W-1:0]    prob_left;
        logic [PROB_W-1:0]    prob_right;
    } t_pair;

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } t_gated;

    typedef struct {
        logic               mono;
        logic [GATE_W-1:0]  gate;
        logic [ALPHA_W-1:0] alpha;
        logic [GAIN_W-1:0]  gain_lo;
        logic [GAIN_W-1:0]  gain_hi;
        logic [PROB_W-1:0]  voice_thr;
        logic [GRACE_W-1:0] grace;
    } t_cfg;

    class gain_scoreboard;
        logic               mono;
        logic [GATE_W-1:0]  gate;
        logic [ALPHA_W-1:0] alpha;
        logic [GAIN_W-1:0]  min_g;
        logic [GAIN_W-1:0]  max_g;
        logic [PROB_W-1:0]  voice_thr;
        logic [GRACE_W-1:0] grace;
        logic [GAIN_W-1:0]  gain_mono;
        logic [GAIN_W-1:0]  gain_left;
        logic [GAIN_W-1:0]  gain_right;
        logic [HB-1:0]      hang_mono;
        logic [HB-1:0]      hang_stereo;
        logic               unmuted;
        t_gated             expected_pairs[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            mono        = RST_MONO_MODE;
            gate        = RST_GATE_THR;
            alpha       = RST_ALPHA;
            min_g       = RST_MIN_GAIN;
            max_g       = RST_MAX_GAIN;
            voice_thr   = RST_VOICE_THR;
            grace       = RST_GRACE;
            gain_mono   = RST_MIN_GAIN;
            gain_left   = RST_MIN_GAIN;
            gain_right  = RST_MIN_GAIN;
            hang_mono   = '0;
            hang_stereo = '0;
            unmuted     = 1'b0;
            mismatches  = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MONO_MODE:    mono      = data[0];
                REG_GATE_THR:     gate      = data[GATE_W-1:0];
                REG_ALPHA:        alpha     = data[ALPHA_W-1:0];
                REG_MIN_GAIN:     min_g     = data[GAIN_W-1:0];
                REG_MAX_GAIN:     max_g     = data[GAIN_W-1:0];
                REG_VOICE_THR:    voice_thr = data[PROB_W-1:0];
                REG_GRACE_BLOCKS: grace     = data[GRACE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [GAIN_W-1:0] smooth_gain(logic [GAIN_W-1:0] g, logic signed [SW-1:0] x);
            longint            mag;
            longint            sum;
            longint            ng;
            logic [GAIN_W-1:0] target;
            mag = (x < 0) ? -longint'(x) : longint'(x);
            target = (unmuted && ((mag << FRAC_BITS) > (longint'(gate) << (SW - 1))))
                     ? max_g : min_g;
            sum = longint'(alpha) * longint'(g)
                + (longint'(ALPHA_ONE) - longint'(alpha)) * longint'(target);
            ng = (sum + 32768) >>> 16;
            if (ng > longint'(max_g)) ng = longint'(max_g);
            if (ng < longint'(min_g)) ng = longint'(min_g);
            return ng[GAIN_W-1:0];
        endfunction

        function logic signed [SW-1:0] scale_sample(logic signed [SW-1:0] x,
                                                     logic [GAIN_W-1:0] g);
            longint q;
            longint hi;
            hi = (longint'(1) << (SW - 1)) - 1;
            q = (longint'(x) * longint'(g) + 16384) >>> FRAC_BITS;
            if (q > hi) q = hi;
            if (q < -hi - 1) q = -hi - 1;
            return q[SW-1:0];
        endfunction

        function void note_item(t_pair p);
            logic [PROB_W-1:0] prob;
            logic [HB-1:0]     cnt;
            logic              voice;
            t_gated            r;
            if (p.frame_start) begin
                prob = (mono || p.prob_left >= p.prob_right) ? p.prob_left : p.prob_right;
                voice = (prob >= voice_thr);
                cnt = mono ? hang_mono : hang_stereo;
                if (voice) begin
                    cnt = '0;
                end else if (cnt != '1) begin
                    cnt = cnt + 1'b1;
                end
                if (mono) hang_mono = cnt;
                else hang_stereo = cnt;
                unmuted = voice || (cnt < grace);
            end
            if (mono) begin
                gain_mono = smooth_gain(gain_mono, p.left);
                r.left = scale_sample(p.left, gain_mono);
                r.right = r.left;
            end else begin
                gain_left = smooth_gain(gain_left, p.left);
                gain_right = smooth_gain(gain_right, p.right);
                r.left = scale_sample(p.left, gain_left);
                r.right = scale_sample(p.right, gain_right);
            end
            expected_pairs.insert(expected_pairs.size(), r);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void check_result(logic signed [SW-1:0] left, logic signed [SW-1:0] right);
            t_gated e;
            results_seen++;
            if (expected_pairs.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected: left %0d right %0d",
                                 results_seen, left, right));
                return;
            end
            e = expected_pairs[0];
            expected_pairs.delete(0);
            if (left !== e.left)
                report($sformatf("result %0d left_out: expected %0d got %0d",
                                 results_seen, e.left, left));
            if (right !== e.right)
                report($sformatf("result %0d right_out: expected %0d got %0d",
                                 results_seen, e.right, right));
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vggs_in_if  #(.SAMPLE_BITS(SW)) in_ch ();
    vggs_out_if #(.SAMPLE_BITS(SW)) out_ch ();

    vad_gated_gain_smoother_top #(
        .SAMPLE_BITS(SW),
        .HANG_BITS  (HB)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    gain_scoreboard sb = new();
    t_cfg cur;
    int   burst_left = 0;
    int   items_sent = 0;
    int   items_in = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready) begin
            sb.note_item('{left: in_ch.left_sample, right: in_ch.right_sample,
                           frame_start: in_ch.frame_start, prob_left: in_ch.voice_prob_left,
                           prob_right: in_ch.voice_prob_right});
            items_in++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.left_out, out_ch.right_out);
    end

    // receiver: stall patterns, one long hold while the sender keeps offering
    initial begin
        int mode;
        int len;
        int period;
        bit held;
        held = 1'b0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (!held && items_in >= HOLD_AFTER) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge clk);
                    out_ch.ready = 1'b0;
                end
            end else begin
                mode = $urandom_range(0, 3);
                len = $urandom_range(10, 200);
                period = $urandom_range(2, 7);
                for (int k = 0; k < len; k++) begin
                    @(negedge clk);
                    case (mode)
                        0: out_ch.ready = 1'b1;
                        1: out_ch.ready = 1'($urandom_range(0, 1));
                        2: out_ch.ready = (k % period) != 0;
                        default: out_ch.ready = ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("vad_gated_gain_smoother_top_test: errors");
        $finish;
    end

    function automatic t_pair mk_pair(int l, int r, bit fs, int pl, int pr);
        t_pair p;
        p.left = SW'(l);
        p.right = SW'(r);
        p.frame_start = fs;
        p.prob_left = PROB_W'(pl);
        p.prob_right = PROB_W'(pr);
        return p;
    endfunction

    function automatic logic signed [SW-1:0] rand_sample(logic [GATE_W-1:0] gate);
        int m;
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
            3, 4, 5, 6: begin
                m = int'(gate) + int'($urandom_range(0, 4)) - 2;
                if (m < 0) m = 0;
                if (m > 32767) m = 32767;
                v = $urandom_range(0, 1) ? -m : m;
            end
            7: begin
                case ($urandom_range(0, 4))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            default: v = int'($urandom_range(0, 511)) - 256;
        endcase
        return SW'(v);
    endfunction

    function automatic logic [PROB_W-1:0] rand_prob(logic [PROB_W-1:0] thr);
        int v;
        case ($urandom_range(0, 5))
            0, 1: v = int'($urandom_range(0, 65535));
            2, 3: begin
                v = int'(thr) + int'($urandom_range(0, 4)) - 2;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
            end
            4: v = 0;
            default: v = 65535;
        endcase
        return PROB_W'(v);
    endfunction

    // kind 1 and 2 drive a hang counter into saturation, mono and stereo
    function automatic t_cfg rand_config(int kind);
        t_cfg c;
        c.mono = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: c.gate = '0;
            1: c.gate = '1;
            2: c.gate = GATE_W'($urandom);
            default: c.gate = GATE_W'($urandom_range(0, 3000));
        endcase
        case ($urandom_range(0, 7))
            0: c.alpha = '0;
            1: c.alpha = '1;
            2, 3: c.alpha = ALPHA_W'($urandom);
            default: c.alpha = ALPHA_W'($urandom_range(50000, 65535));
        endcase
        case ($urandom_range(0, 7))
            0: c.gain_lo = '0;
            1: c.gain_lo = GAIN_W'(36045);
            2: c.gain_lo = GAIN_W'($urandom);
            default: c.gain_lo = GAIN_W'($urandom_range(0, 8000));
        endcase
        case ($urandom_range(0, 7))
            0: c.gain_hi = '0;
            1: c.gain_hi = GAIN_W'(36045);
            2: c.gain_hi = GAIN_W'($urandom);
            3: c.gain_hi = '1;
            default: c.gain_hi = GAIN_W'($urandom_range(20000, 36045));
        endcase
        case ($urandom_range(0, 5))
            0: c.voice_thr = '0;
            1: c.voice_thr = '1;
            default: c.voice_thr = PROB_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: c.grace = '0;
            1: c.grace = '1;
            default: c.grace = GRACE_W'($urandom_range(0, 40));
        endcase
        if (kind != 0) begin
            c.mono = (kind == 1);
            c.voice_thr = '1;
            c.grace = '1;
        end
        return c;
    endfunction

    task automatic send_pair(input t_pair p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge clk);
                in_ch.valid = 1'b0;
                in_ch.left_sample = SW'($urandom);
                in_ch.right_sample = SW'($urandom);
                in_ch.frame_start = 1'($urandom);
                in_ch.voice_prob_left = PROB_W'($urandom);
                in_ch.voice_prob_right = PROB_W'($urandom);
            end
        end
        @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.left_sample = p.left;
        in_ch.right_sample = p.right;
        in_ch.frame_start = p.frame_start;
        in_ch.voice_prob_left = p.prob_left;
        in_ch.voice_prob_right = p.prob_right;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        sb.write_reg(idx, data);
    endtask

    // bits above each register's width carry noise
    task automatic apply_config(input t_cfg c);
        drain();
        write_reg(REG_MONO_MODE, {15'($urandom), c.mono});
        write_reg(REG_GATE_THR, {1'($urandom), c.gate});
        write_reg(REG_ALPHA, c.alpha);
        write_reg(REG_MIN_GAIN, c.gain_lo);
        write_reg(REG_MAX_GAIN, c.gain_hi);
        write_reg(REG_VOICE_THR, c.voice_thr);
        write_reg(REG_GRACE_BLOCKS, {8'($urandom), c.grace});
        write_reg(REG_NONE, CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cur = c;
    endtask

    task automatic directed_part();
        t_cfg c;
        send_pair(mk_pair(0, 0, 0, 0, 0));
        send_pair(mk_pair(32767, 0, 0, 0, 0));
        send_pair(mk_pair(-32768, 0, 0, 0, 0));
        // probability equal to threshold is voice, sample one above the gate
        send_pair(mk_pair(34, 0, 1, RST_VOICE_THR, 0));
        send_pair(mk_pair(33, 0, 0, 0, 0));
        send_pair(mk_pair(-34, 0, 0, 0, 0));
        send_pair(mk_pair(32767, 0, 0, 0, 0));
        send_pair(mk_pair(-32768, 0, 0, 0, 0));
        // mono ignores the right probability
        send_pair(mk_pair(1000, 0, 1, RST_VOICE_THR - 1, 65535));
        send_pair(mk_pair(-1, 0, 1, 65535, 0));
        send_pair(mk_pair(20000, 0, 1, 0, 0));
        c = cur;
        c.mono = 1'b0;
        apply_config(c);
        send_pair(mk_pair(32767, -32768, 1, 100, 65535));
        send_pair(mk_pair(-5000, 5000, 1, 65535, 0));
        send_pair(mk_pair(0, 32767, 1, 0, 0));
        send_pair(mk_pair(-32768, -32768, 0, 0, 0));
        // min above max
        c.gain_lo = GAIN_W'(40000);
        c.gain_hi = GAIN_W'(1000);
        c.alpha = '0;
        apply_config(c);
        send_pair(mk_pair(32767, -32768, 0, 0, 0));
        send_pair(mk_pair(100, -100, 1, 65535, 65535));
        // gains beyond unity saturate the output
        c.gain_lo = '1;
        c.gain_hi = '1;
        c.alpha = '1;
        c.gate = '0;
        apply_config(c);
        send_pair(mk_pair(32767, -32768, 1, 65535, 65535));
        send_pair(mk_pair(-1, 1, 0, 0, 0));
        send_pair(mk_pair(0, 0, 0, 0, 0));
        // back to mono, flag from the stereo frame still holds
        c = rand_config(0);
        c.mono = 1'b1;
        apply_config(c);
        send_pair(mk_pair(5000, 0, 0, 0, 0));
        send_pair(mk_pair(-5000, 7, 0, 0, 0));
    endtask

    task automatic run_phase(input int n, input int kind);
        t_pair p;
        int    frame_left;
        frame_left = 0;
        repeat (n) begin
            p.left = rand_sample(cur.gate);
            p.right = rand_sample(cur.gate);
            p.prob_left = PROB_W'($urandom);
            p.prob_right = PROB_W'($urandom);
            if (kind != 0) begin
                p.frame_start = 1'b1;
                p.prob_left = PROB_W'($urandom_range(0, 65534));
                p.prob_right = PROB_W'($urandom_range(0, 65534));
            end else if ($urandom_range(0, 9) == 0) begin
                p.frame_start = 1'($urandom_range(0, 1));
            end else begin
                p.frame_start = (frame_left == 0);
                if (p.frame_start) begin
                    frame_left = $urandom_range(1, 12);
                    p.prob_left = rand_prob(cur.voice_thr);
                    p.prob_right = rand_prob(cur.voice_thr);
                end
                frame_left--;
            end
            send_pair(p);
        end
    endtask

    initial begin
        int phase;
        int kind;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.left_sample = '0;
        in_ch.right_sample = '0;
        in_ch.frame_start = 1'b0;
        in_ch.voice_prob_left = '0;
        in_ch.voice_prob_right = '0;
        rst_n = 1'b0;
        cur = '{mono: RST_MONO_MODE, gate: RST_GATE_THR, alpha: RST_ALPHA,
                gain_lo: RST_MIN_GAIN, gain_hi: RST_MAX_GAIN,
                voice_thr: RST_VOICE_THR, grace: RST_GRACE};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        directed_part();
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            kind = (phase == 2) ? 1 : (phase == 5) ? 2 : 0;
            apply_config(rand_config(kind));
            run_phase((kind != 0) ? HANG_ITEMS : $urandom_range(60, 150), kind);
            phase++;
        end
        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("vad_gated_gain_smoother_top_test: clean");
        end else begin
            $display("vad_gated_gain_smoother_top_test: errors");
        end
        $finish;
    end

endmodule
